// ===== rtl/rip_pkg.sv =====
// Shared types, widths and codes for the rotary indexing table plant step.
// Used by rtl/rotary_indexer_plant_step.sv; depends on nothing else.
`default_nettype none

package rip_pkg;

    localparam int ANGLE_W    = 20;
    localparam int DIFF_W     = ANGLE_W + 1;
    localparam int SPD_W      = 16;
    localparam int DMS_W      = 10;
    localparam int STEP_W     = SPD_W + DMS_W;
    localparam int TIMER_W    = 17;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic signed [ANGLE_W-1:0] RST_LOAD_ANGLE = 20'sd0;
    localparam logic signed [ANGLE_W-1:0] RST_PICK_ANGLE = 20'sd184320;
    localparam logic [SPD_W-1:0]          RST_SLEW       = 16'd92;
    localparam logic [SPD_W-1:0]          RST_LOAD_DELAY = 16'd1000;
    localparam logic [SPD_W-1:0]          RST_TOLERANCE  = 16'd1024;
    localparam logic [TIMER_W-1:0]        TIMER_MAX      = {TIMER_W{1'b1}};

    // Item kinds carried on the input tuser.
    typedef enum logic [ACT_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_LOAD = 2'd1,
        ACT_TAKE = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_ENABLE  = 3'd0,
        CFG_LOAD_ANGLE  = 3'd1,
        CFG_PICK_ANGLE  = 3'd2,
        CFG_SLEW        = 3'd3,
        CFG_LOAD_DELAY  = 3'd4,
        CFG_TOLERANCE   = 3'd5
    } t_cfg_reg;

    // True when the two angles lie within tol of each other.
    function automatic logic f_within(input logic signed [ANGLE_W-1:0] a,
                                      input logic signed [ANGLE_W-1:0] b,
                                      input logic [SPD_W-1:0] tol);
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        diff = {a[ANGLE_W-1], a} - {b[ANGLE_W-1], b};
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        return mag <= {{(DIFF_W-SPD_W){1'b0}}, tol};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rotary_indexer_plant_step.sv =====
// Rotary indexing table plant step: configuration registers, plant state and
// a three-register pipeline from input item to status item.
// Depends on rtl/rip_pkg.sv.
// Throughput: one item per cycle while results are taken; while the receiver
// holds off, up to three items wait in the pipeline before o_s_tready drops.
// Reset (i_rst_n low, synchronous): pipeline emptied, table at angle 0 with no
// part and a cleared load timer, configuration registers at their defaults.
`default_nettype none

module rotary_indexer_plant_step (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input items.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [9:0] delta_ms, [10] ctrl_enable, [11] ctrl_index, [12] ctrl_load,
    // [13] ctrl_reset, [15:14] zero.
    input  wire logic [rip_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] action.
    input  wire logic [rip_pkg::ACT_W-1:0]      i_s_tuser,
    // Result items.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [19:0] angle_now, [20] has_part, [21] pick_ready, [22] at_load,
    // [23] at_pick, [24] busy_res, [25] accepted, [31:26] zero.
    output logic [rip_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // Configuration writes.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rip_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = rip_pkg::ANGLE_W;
    localparam int DW = rip_pkg::DIFF_W;
    localparam int SW = rip_pkg::STEP_W;
    localparam int TW = rip_pkg::TIMER_W;

    // Configuration registers. Writes are always taken.
    logic                                r_run_enable;
    logic signed [AW-1:0]                r_load_angle;
    logic signed [AW-1:0]                r_pick_angle;
    logic [rip_pkg::SPD_W-1:0]           r_slew;
    logic [rip_pkg::SPD_W-1:0]           r_load_delay;
    logic [rip_pkg::SPD_W-1:0]           r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= 1'b0;
            r_load_angle <= rip_pkg::RST_LOAD_ANGLE;
            r_pick_angle <= rip_pkg::RST_PICK_ANGLE;
            r_slew       <= rip_pkg::RST_SLEW;
            r_load_delay <= rip_pkg::RST_LOAD_DELAY;
            r_tol        <= rip_pkg::RST_TOLERANCE;
        end else if (i_cfg_valid) begin
            case (rip_pkg::t_cfg_reg'(i_cfg_index))
                rip_pkg::CFG_RUN_ENABLE: r_run_enable <= i_cfg_data[0];
                rip_pkg::CFG_LOAD_ANGLE: r_load_angle <= i_cfg_data[AW-1:0];
                rip_pkg::CFG_PICK_ANGLE: r_pick_angle <= i_cfg_data[AW-1:0];
                rip_pkg::CFG_SLEW:       r_slew       <= i_cfg_data[rip_pkg::SPD_W-1:0];
                rip_pkg::CFG_LOAD_DELAY: r_load_delay <= i_cfg_data[rip_pkg::SPD_W-1:0];
                rip_pkg::CFG_TOLERANCE:  r_tol        <= i_cfg_data[rip_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline has three registers: the input stage A, the state-update
    // stage B and the output register. Each stage fills whenever it is empty
    // or its content moves on, so bubbles are squeezed out and a waiting
    // result stops new items only once stages A and B are full as well.
    logic o_take;     // output register can load this cycle
    logic b_take;     // stage B can load this cycle
    logic a_take;     // stage A can load this cycle
    logic a_fire;     // the item in stage A updates the plant state
    logic b_fire;     // the item in stage B moves into the output register

    logic                         r_a_valid;
    rip_pkg::t_action             r_a_action;
    logic [rip_pkg::DMS_W-1:0]    r_a_dms;
    logic                         r_a_en;
    logic                         r_a_idx;
    logic                         r_a_ld;
    logic                         r_a_rst;
    logic [SW-1:0]                r_a_step;

    logic                         r_b_valid;
    logic                         r_b_ok;

    logic                         r_o_valid;
    logic [rip_pkg::OUT_DATA_W-1:0] r_o_data;

    assign o_take = !r_o_valid || i_m_tready;
    assign b_fire = r_b_valid && o_take;
    assign b_take = !r_b_valid || o_take;
    assign a_fire = r_a_valid && b_take;
    assign a_take = !r_a_valid || b_take;

    assign o_s_tready = a_take;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // Stage A: the slew step for the elapsed time is multiplied out here, so
    // the state-update stage sees it as a plain operand.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_take) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take && i_s_tvalid) begin
            r_a_action <= rip_pkg::t_action'(i_s_tuser);
            r_a_dms    <= i_s_tdata[rip_pkg::DMS_W-1:0];
            r_a_en     <= i_s_tdata[10];
            r_a_idx    <= i_s_tdata[11];
            r_a_ld     <= i_s_tdata[12];
            r_a_rst    <= i_s_tdata[13];
            r_a_step   <= {{(SW-rip_pkg::SPD_W){1'b0}}, r_slew}
                        * {{(SW-rip_pkg::DMS_W){1'b0}}, i_s_tdata[rip_pkg::DMS_W-1:0]};
        end
    end

    // Plant state.
    logic signed [AW-1:0] r_cur;
    logic signed [AW-1:0] r_tgt;
    logic                 r_hold;
    logic [TW-1:0]        r_timer;

    logic signed [AW-1:0] n_cur;
    logic signed [AW-1:0] n_tgt;
    logic                 n_hold;
    logic [TW-1:0]        n_timer;
    logic                 n_ok;

    // Intermediate values of a tick.
    logic signed [AW-1:0] tk_cur;
    logic signed [AW-1:0] tk_tgt;
    logic                 tk_hold;
    logic [TW-1:0]        tk_timer;
    logic                 tk_atl;
    logic [TW:0]          tk_sum;
    logic [TW-1:0]        tk_sat;
    logic signed [DW-1:0] tk_diff;
    logic [DW-1:0]        tk_mag;

    always_comb begin
        n_cur    = r_cur;
        n_tgt    = r_tgt;
        n_hold   = r_hold;
        n_timer  = r_timer;
        n_ok     = 1'b0;

        // A tick first applies the reset bit, then the load and index
        // requests, then slews the angle toward the target.
        tk_cur   = r_a_rst ? r_load_angle : r_cur;
        tk_tgt   = r_a_rst ? r_load_angle : r_tgt;
        tk_hold  = r_a_rst ? 1'b0 : r_hold;
        tk_timer = r_a_rst ? '0 : r_timer;
        tk_atl   = rip_pkg::f_within(tk_cur, r_load_angle, r_tol);
        tk_sum   = {1'b0, tk_timer} + {{(TW+1-rip_pkg::DMS_W){1'b0}}, r_a_dms};
        tk_sat   = tk_sum[TW] ? rip_pkg::TIMER_MAX : tk_sum[TW-1:0];
        if (r_a_en) begin
            if (r_a_ld && !tk_hold && tk_atl) begin
                if (tk_sat >= {{(TW-rip_pkg::SPD_W){1'b0}}, r_load_delay}) begin
                    tk_hold  = 1'b1;
                    tk_timer = '0;
                end else begin
                    tk_timer = tk_sat;
                end
            end else begin
                tk_timer = '0;
            end
            if (r_a_idx && tk_hold && tk_atl) begin
                tk_tgt = r_pick_angle;
            end
        end
        tk_diff = {tk_tgt[AW-1], tk_tgt} - {tk_cur[AW-1], tk_cur};
        tk_mag  = tk_diff[DW-1] ? DW'(-tk_diff) : DW'(tk_diff);

        case (r_a_action)
            rip_pkg::ACT_TICK: begin
                n_ok = 1'b1;
                if (r_run_enable) begin
                    n_tgt   = tk_tgt;
                    n_hold  = tk_hold;
                    n_timer = tk_timer;
                    // A step larger than the gap lands on the target; a
                    // smaller one is below 2**20 and fits the angle width.
                    if ({{(SW-DW){1'b0}}, tk_mag} > r_a_step) begin
                        n_cur = tk_diff[DW-1] ? tk_cur - r_a_step[AW-1:0]
                                              : tk_cur + r_a_step[AW-1:0];
                    end else begin
                        n_cur = tk_tgt;
                    end
                end
            end
            rip_pkg::ACT_LOAD: begin
                if (!r_hold && rip_pkg::f_within(r_cur, r_load_angle, r_tol)) begin
                    n_hold  = 1'b1;
                    n_timer = '0;
                    n_ok    = 1'b1;
                end
            end
            rip_pkg::ACT_TAKE: begin
                if (r_hold && rip_pkg::f_within(r_cur, r_pick_angle, r_tol)) begin
                    n_hold = 1'b0;
                    n_tgt  = r_load_angle;
                    n_ok   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_tgt   <= '0;
            r_hold  <= 1'b0;
            r_timer <= '0;
        end else if (a_fire) begin
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_hold  <= n_hold;
            r_timer <= n_timer;
        end
    end

    // Stage B carries the accepted flag. The state registers hold exactly
    // this item's effects while it sits here, because a later item updates
    // them only on the edge at which this one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_take) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_ok <= n_ok;
        end
    end

    // Output register: status flags are worked out from the settled state.
    logic st_atl;
    logic st_atp;
    logic st_busy;

    assign st_atl  = rip_pkg::f_within(r_cur, r_load_angle, r_tol);
    assign st_atp  = rip_pkg::f_within(r_cur, r_pick_angle, r_tol);
    assign st_busy = !rip_pkg::f_within(r_cur, r_tgt, r_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_take) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_o_data <= {6'b0, r_b_ok, st_busy, st_atp, st_atl,
                         r_hold && st_atp, r_hold, r_cur};
        end
    end

    // A part on the table always comes with a cleared load timer.
    a_hold_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |-> (r_timer == '0))
        else $error("load timer running while a part is present");

    // A tick while stopped leaves the table where it is.
    a_stopped_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && (r_a_action == rip_pkg::ACT_TICK) && !r_run_enable)
        |=> ($stable(r_cur) && $stable(r_tgt) && $stable(r_hold)))
        else $error("stopped tick changed the plant state");

    // A successful robot take sends the table back to the load angle.
    a_take_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && (r_a_action == rip_pkg::ACT_TAKE) && n_ok)
        |=> (!r_hold && (r_tgt == r_load_angle)))
        else $error("robot take did not clear the part and retarget");

    // Ready to pick is reported only together with a part at the pick angle.
    a_ready_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_data[21] == (r_o_data[20] && r_o_data[23])))
        else $error("pick_ready inconsistent with part and pick flags");

endmodule

`default_nettype wire

// ===== tb/rotary_indexer_plant_step_tb.sv =====
// Self-checking testbench for the rotary indexing table plant step.
// Needs rtl/rip_pkg.sv and rtl/rotary_indexer_plant_step.sv; a built-in table
// predictor checks every status item under random idling on both streams.
`default_nettype none

module rotary_indexer_plant_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One input item: the action travels on tuser, the rest on tdata.
    typedef struct packed {
        rip_pkg::t_action act;
        logic             rst;
        logic             ld;
        logic             idx;
        logic             en;
        logic [9:0]       dms;
    } t_table_item;

    // One status item, laid out exactly as o_m_tdata (angle in the low bits).
    typedef struct packed {
        logic [5:0]  pad;
        logic        accepted;
        logic        busy;
        logic        at_pick;
        logic        at_load;
        logic        pick_ready;
        logic        has_part;
        logic [19:0] angle_now;
    } t_table_status;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [rip_pkg::IN_DATA_W-1:0]  i_s_tdata;
    logic [rip_pkg::ACT_W-1:0]      i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [rip_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [rip_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rip_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // The item currently offered on the input stream.
    t_table_item s_item = '0;

    assign i_s_tdata = {2'b00, s_item.rst, s_item.ld, s_item.idx, s_item.en, s_item.dms};
    assign i_s_tuser = s_item.act;

    rotary_indexer_plant_step u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Table predictor: its own copy of the registers and the plant state.
    // ------------------------------------------------------------------
    logic               cfg_run      = 1'b0;
    logic signed [19:0] cfg_load_ang = rip_pkg::RST_LOAD_ANGLE;
    logic signed [19:0] cfg_pick_ang = rip_pkg::RST_PICK_ANGLE;
    logic [15:0]        cfg_slew     = rip_pkg::RST_SLEW;
    logic [15:0]        cfg_delay    = rip_pkg::RST_LOAD_DELAY;
    logic [15:0]        cfg_tol      = rip_pkg::RST_TOLERANCE;

    logic signed [19:0] tbl_angle  = '0;
    logic signed [19:0] tbl_target = '0;
    logic               tbl_part   = 1'b0;
    logic [16:0]        tbl_timer  = '0;

    // Run statistics for the closing summary.
    int items_in     = 0;
    int results_seen = 0;
    int timer_loads  = 0;
    int direct_loads = 0;
    int robot_takes  = 0;
    int mismatches   = 0;

    t_table_item   item_backlog[$];
    t_table_status status_expect_q[$];

    // True when two angles lie within the tolerance window of each other.
    function automatic logic angles_match(input logic signed [19:0] a,
                                          input logic signed [19:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return d <= longint'(cfg_tol);
    endfunction

    // Applies one item to the predicted table and returns its status.
    function automatic t_table_status table_advance(input t_table_item it);
        t_table_status r;
        logic          ok;
        logic          near_ld;
        longint        sum;
        longint        diff;
        longint        stp;
        longint        mag;
        r  = '0;
        ok = 1'b0;
        case (it.act)
            rip_pkg::ACT_TICK: begin
                ok = 1'b1;
                // A stopped table reports its state but keeps it.
                if (cfg_run) begin
                    if (it.rst) begin
                        tbl_part   = 1'b0;
                        tbl_angle  = cfg_load_ang;
                        tbl_target = cfg_load_ang;
                        tbl_timer  = '0;
                    end
                    if (it.en) begin
                        near_ld = angles_match(tbl_angle, cfg_load_ang);
                        // The load timer only runs while a load request persists at
                        // the load station with an empty table.
                        if (it.ld && !tbl_part && near_ld) begin
                            sum = longint'(tbl_timer) + longint'(it.dms);
                            tbl_timer = (sum > longint'(rip_pkg::TIMER_MAX))
                                      ? rip_pkg::TIMER_MAX : 17'(sum);
                            if (tbl_timer >= cfg_delay) begin
                                tbl_part  = 1'b1;
                                tbl_timer = '0;
                                timer_loads++;
                            end
                        end else begin
                            tbl_timer = '0;
                        end
                        if (it.idx && tbl_part && near_ld) tbl_target = cfg_pick_ang;
                    end
                    // Slew toward the target, landing on it once within one step.
                    diff = longint'(tbl_target) - longint'(tbl_angle);
                    stp  = longint'(cfg_slew) * longint'(it.dms);
                    mag  = (diff < 0) ? -diff : diff;
                    if (mag > stp) begin
                        tbl_angle = 20'(longint'(tbl_angle) + ((diff < 0) ? -stp : stp));
                    end else begin
                        tbl_angle = tbl_target;
                    end
                end
            end
            rip_pkg::ACT_LOAD: begin
                if (!tbl_part && angles_match(tbl_angle, cfg_load_ang)) begin
                    tbl_part  = 1'b1;
                    tbl_timer = '0;
                    ok = 1'b1;
                    direct_loads++;
                end
            end
            rip_pkg::ACT_TAKE: begin
                if (tbl_part && angles_match(tbl_angle, cfg_pick_ang)) begin
                    tbl_part   = 1'b0;
                    tbl_target = cfg_load_ang;
                    ok = 1'b1;
                    robot_takes++;
                end
            end
            default: begin
            end
        endcase
        r.angle_now  = tbl_angle;
        r.has_part   = tbl_part;
        r.at_load    = angles_match(tbl_angle, cfg_load_ang);
        r.at_pick    = angles_match(tbl_angle, cfg_pick_ang);
        r.pick_ready = tbl_part && r.at_pick;
        r.busy       = !angles_match(tbl_angle, tbl_target);
        r.accepted   = ok;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idling: most gaps are short, a few are long. With steady_flow set
    // neither side idles at all.
    // ------------------------------------------------------------------
    bit steady_flow = 1'b0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input driver. s_taken records whether the offered item was accepted
    // at the last rising edge; the driver only moves on after that.
    // ------------------------------------------------------------------
    logic s_taken = 1'b0;
    int   tx_gap  = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_tvalid <= 1'b0;
            end else if (item_backlog.size() != 0) begin
                s_item     <= item_backlog.pop_front();
                i_s_tvalid <= 1'b1;
                tx_gap = idle_len();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver. A long hold-off, counted by its own process, lets the
    // block fill up while the driver keeps offering items.
    // ------------------------------------------------------------------
    int   rx_hold_left = 0;
    logic rx_hold      = 1'b0;
    int   rx_stall     = 0;

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rx_hold <= 1'b1;
        end else begin
            rx_hold <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            i_m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            rx_stall = idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input item and checks every
    // accepted status item against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch in %s of status item %0d: expected 0x%0h, got 0x%0h",
                         $realtime, name, results_seen, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_table_status want;
        t_table_status got;
        if (!i_rst_n) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                status_expect_q.push_back(table_advance(s_item));
                items_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                results_seen++;
                if (status_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] status item 0x%08h arrived with none expected",
                                 $realtime, got);
                    end
                end else begin
                    want = status_expect_q.pop_front();
                    check_field("angle_now", want.angle_now, got.angle_now);
                    check_field("has_part", want.has_part, got.has_part);
                    check_field("pick_ready", want.pick_ready, got.pick_ready);
                    check_field("at_load", want.at_load, got.at_load);
                    check_field("at_pick", want.at_pick, got.at_pick);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("accepted", want.accepted, got.accepted);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic add_item(input rip_pkg::t_action a, input int d, input bit en,
                            input bit idx, input bit ld, input bit rst);
        t_table_item it;
        it.act = a;
        it.dms = 10'(d);
        it.en  = en;
        it.idx = idx;
        it.ld  = ld;
        it.rst = rst;
        item_backlog.push_back(it);
    endtask

    // Elapsed time: the extremes now and then, otherwise anything in range.
    function automatic int rand_dms();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 1000;
        return $urandom_range(0, 1000);
    endfunction

    function automatic bit coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Queues one working cycle of the table: reset to the load station, load
    // a part, index to the pick station, let the robot take it and return.
    // The content is random, so cycles also stall halfway or fail.
    task automatic queue_cycle();
        int n;
        add_item(rip_pkg::ACT_TICK, rand_dms(), coin(50), 1'b0, coin(50), 1'b1);
        n = $urandom_range(1, 4);
        repeat (n) begin
            if (coin(20)) begin
                add_item(rip_pkg::ACT_LOAD, rand_dms(), coin(50), coin(50), coin(50),
                         coin(50));
            end else begin
                add_item(rip_pkg::ACT_TICK, rand_dms(), 1'b1, coin(20), 1'b1, 1'b0);
            end
        end
        n = $urandom_range(1, 2);
        repeat (n) add_item(rip_pkg::ACT_TICK, rand_dms(), 1'b1, 1'b1, coin(30), 1'b0);
        n = $urandom_range(1, 4);
        repeat (n) add_item(rip_pkg::ACT_TICK, rand_dms(), coin(50), coin(50), coin(20), 1'b0);
        add_item(rip_pkg::ACT_TAKE, rand_dms(), coin(50), coin(50), coin(50), coin(50));
        if (coin(50)) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                add_item(rip_pkg::ACT_TICK, rand_dms(), coin(50), coin(20), coin(20), 1'b0);
            end
        end
    endtask

    // Any item at all, the unused action code included.
    task automatic queue_noise();
        add_item(rip_pkg::t_action'($urandom_range(0, 3)), rand_dms(), coin(50), coin(50),
                 coin(50), coin(12));
    endtask

    // Mostly working cycles, the rest noise, until about count items are queued.
    task automatic queue_random(input int count);
        int target;
        target = item_backlog.size() + count;
        while (item_backlog.size() < target) begin
            if (coin(80)) queue_cycle();
            else repeat ($urandom_range(1, 3)) queue_noise();
        end
    endtask

    // Waits until every queued item went in and every status item came out,
    // then lets the pipeline settle before the registers may change.
    task automatic drain();
        while (item_backlog.size() != 0 || i_s_tvalid || status_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input rip_pkg::t_cfg_reg r, input logic [19:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (r)
            rip_pkg::CFG_RUN_ENABLE: cfg_run      = v[0];
            rip_pkg::CFG_LOAD_ANGLE: cfg_load_ang = v;
            rip_pkg::CFG_PICK_ANGLE: cfg_pick_ang = v;
            rip_pkg::CFG_SLEW:       cfg_slew     = v[15:0];
            rip_pkg::CFG_LOAD_DELAY: cfg_delay    = v[15:0];
            rip_pkg::CFG_TOLERANCE:  cfg_tol      = v[15:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_table(input bit run, input int load, input int pick, input int slew,
                             input int delay, input int tol);
        cfg_write(rip_pkg::CFG_RUN_ENABLE, 20'(run));
        cfg_write(rip_pkg::CFG_LOAD_ANGLE, 20'(load));
        cfg_write(rip_pkg::CFG_PICK_ANGLE, 20'(pick));
        cfg_write(rip_pkg::CFG_SLEW, 20'(slew));
        cfg_write(rip_pkg::CFG_LOAD_DELAY, 20'(delay));
        cfg_write(rip_pkg::CFG_TOLERANCE, 20'(tol));
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Stopped table at the reset settings: ticks change nothing, while a direct
        // load still acts and a take off the pick station is refused. The unused action is refused.
        add_item(rip_pkg::ACT_TICK, 1000, 1'b1, 1'b1, 1'b1, 1'b1);
        add_item(rip_pkg::ACT_LOAD, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(rip_pkg::ACT_TAKE, 1000, 1'b1, 1'b1, 1'b1, 1'b1);
        add_item(rip_pkg::ACT_NONE, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(rip_pkg::ACT_LOAD, 1000, 1'b1, 1'b1, 1'b1, 1'b1);
        drain();

        // Running table at the default geometry: one full working cycle by hand.
        set_table(1'b1, 0, 184320, 92, 1000, 1024);
        add_item(rip_pkg::ACT_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b1);     // back to load, no part
        add_item(rip_pkg::ACT_TICK, 999, 1'b1, 1'b0, 1'b1, 1'b0);   // timer one short
        add_item(rip_pkg::ACT_TICK, 1, 1'b1, 1'b0, 1'b1, 1'b0);     // part appears
        add_item(rip_pkg::ACT_LOAD, 1000, 1'b1, 1'b1, 1'b1, 1'b1);  // refused, part present
        add_item(rip_pkg::ACT_TICK, 0, 1'b1, 1'b1, 1'b0, 1'b0);     // index, no time passing
        add_item(rip_pkg::ACT_TICK, 1000, 1'b0, 1'b0, 1'b0, 1'b0);  // halfway
        add_item(rip_pkg::ACT_TAKE, 517, 1'b1, 1'b1, 1'b1, 1'b1);   // refused, not at pick
        add_item(rip_pkg::ACT_TICK, 1000, 1'b0, 1'b1, 1'b0, 1'b0);  // inside the pick window
        add_item(rip_pkg::ACT_TAKE, 0, 1'b0, 1'b0, 1'b0, 1'b0);     // robot takes the part
        add_item(rip_pkg::ACT_NONE, 1000, 1'b1, 1'b1, 1'b1, 1'b1);
        add_item(rip_pkg::ACT_TICK, 1000, 1'b1, 1'b0, 1'b1, 1'b0);  // load request off station
        add_item(rip_pkg::ACT_TICK, 1000, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(rip_pkg::ACT_TICK, 500, 1'b1, 1'b1, 1'b1, 1'b1);   // every control bit
        queue_random(260);
        drain();

        // Widest stations, fastest slew, no load delay and a zero window. The
        // part appears on the same tick that the load request starts.
        steady_flow = 1'b1;
        set_table(1'b1, -368640, 368640, 65535, 0, 0);
        add_item(rip_pkg::ACT_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b1);
        add_item(rip_pkg::ACT_TICK, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(rip_pkg::ACT_TICK, 1000, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(rip_pkg::ACT_TAKE, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_random(260);
        drain();

        // Stations swapped to the other extremes, a frozen table, the longest
        // load delay and the widest window.
        steady_flow = 1'b0;
        set_table(1'b1, 368640, -368640, 0, 65535, 65535);
        queue_random(160);
        drain();

        // Random geometry, with the receiver holding off for a long stretch
        // while the driver keeps offering items.
        set_table(1'b1, int'($urandom_range(0, 737280)) - 368640,
                  int'($urandom_range(0, 737280)) - 368640, $urandom_range(50, 5000),
                  $urandom_range(0, 3000), $urandom_range(0, 4096));
        queue_random(320);
        @(posedge i_clk);
        rx_hold_left = 400;
        drain();

        // Table stopped again, random geometry.
        steady_flow = 1'b1;
        set_table(1'b0, int'($urandom_range(0, 737280)) - 368640,
                  int'($urandom_range(0, 737280)) - 368640, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
        queue_random(100);
        drain();

        $display("Summary: %0d items in, %0d status items checked over six register settings",
                 items_in, results_seen);
        $display("Summary: %0d parts loaded by timer, %0d loaded directly, %0d taken",
                 timer_loads, direct_loads, robot_takes);
        if (mismatches == 0 && status_expect_q.size() == 0) begin
            $display("rotary_indexer_plant_step_tb passed");
        end else begin
            $display("rotary_indexer_plant_step_tb failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #15ms;
        $display("Timeout with %0d status items still expected", status_expect_q.size());
        $display("rotary_indexer_plant_step_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
